[sv/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_WIDTH        = 7;   // width of the window_size register
  localparam int WINDOW_RESET     = 3;   // window_size after reset

  // Compare results that each cell hands to its neighbors.
  typedef struct packed {
    logic le_new;   // stored key <= incoming sample
    logic ge_old;   // stored key >= sample being evicted
  } swm_flags_t;

  // Per-transaction control broadcast to every cell.
  typedef struct packed {
    logic step;     // a sample is accepted this cycle
    logic evict;    // the window is full, oldest sample leaves
  } swm_ctrl_t;

endpackage

[sv/swm_ram.sv]
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window. Each step it keeps its key, takes the key
// of the neighbor above (eviction closes the gap), the key of the neighbor
// below (insertion opens a gap) or the new sample.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CW           = 7,
  parameter int INDEX        = 0
) (
  input  logic                           clk,
  input  swm_ctrl_t                      ctrl,
  input  logic [CW-1:0]                  live_cnt,  // entries left after eviction
  input  logic signed [SAMPLE_WIDTH-1:0] new_key,
  input  logic signed [SAMPLE_WIDTH-1:0] old_key,
  input  logic signed [SAMPLE_WIDTH-1:0] key_lo,
  input  swm_flags_t                     flg_lo,
  input  logic signed [SAMPLE_WIDTH-1:0] key_hi,
  input  swm_flags_t                     flg_hi,
  output logic signed [SAMPLE_WIDTH-1:0] key,
  output swm_flags_t                     flg,
  output logic signed [SAMPLE_WIDTH-1:0] key_next
);

  localparam int IXW = (CW > 32) ? CW : 32;

  logic signed [SAMPLE_WIDTH-1:0] d_own;
  logic signed [SAMPLE_WIDTH-1:0] d_lo;
  logic                           d_own_le;
  logic                           d_lo_le;
  logic                           own_live;
  logic                           keep;
  logic                           take_new;

  assign flg.le_new = (key <= new_key);
  assign flg.ge_old = (key >= old_key);

  always_comb begin
    // view of the window with the evicted entry removed
    d_own    = (ctrl.evict && flg.ge_old) ? key_hi : key;
    d_own_le = (ctrl.evict && flg.ge_old) ? flg_hi.le_new : flg.le_new;
    d_lo     = (ctrl.evict && flg_lo.ge_old) ? key : key_lo;
    d_lo_le  = (ctrl.evict && flg_lo.ge_old) ? flg.le_new : flg_lo.le_new;
    own_live = (IXW'(INDEX) < IXW'(live_cnt));
    keep     = own_live && d_own_le;
    take_new = (INDEX == 0) || d_lo_le;
    if (keep) begin
      key_next = d_own;
    end else if (take_new) begin
      key_next = new_key;
    end else begin
      key_next = d_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      key <= key_next;
    end
  end

endmodule

[sv/sliding_window_median_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running lower median over the last window_size samples.
// ----------------------------------------------------------------------------
// Result: the median of a transaction is valid in the cycle after the sample
//   is accepted; no result until the window has filled.
// Throughput: one sample per cycle unless the output stalls or window_size is
//   written; each sample updates all cells, ring RAM prefetches next oldest.
// Reset: window_size = 3, window empty. Writing window_size empties it too.
// ----------------------------------------------------------------------------
module sliding_window_median_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           window_size_we,
  input  logic [CFG_WIDTH-1:0]           window_size,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           median_valid,
  input  logic                           median_ready,
  output logic signed [SAMPLE_WIDTH-1:0] median
);

  localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int XW    = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
  localparam int K_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  // window length, fill count and oldest ring slot
  logic [CW-1:0] win_len;
  logic [CW-1:0] win_len_next;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_count_next;
  logic [PW-1:0] oldest_ptr;
  logic [PW-1:0] oldest_ptr_next;

  logic          accept;
  logic          full;
  logic          result;
  logic          ring_we;
  logic [PW-1:0] ring_waddr;
  logic [CW-1:0] live_cnt;
  logic [CW-1:0] mid_rank;
  logic [XW-1:0] ws_ext;
  swm_ctrl_t     ctrl;

  // evicted-sample prefetch with write-through for a same-slot read
  logic [SAMPLE_WIDTH-1:0]        ring_rdata;
  logic                           byp_hit;
  logic signed [SAMPLE_WIDTH-1:0] byp_data;
  logic signed [SAMPLE_WIDTH-1:0] old_key;

  // the cell row
  logic signed [SAMPLE_WIDTH-1:0] cell_key  [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_next [WINDOW_MAX];
  swm_flags_t                     cell_flg  [WINDOW_MAX];

  // one output register parts the two sides; no sample is taken while
  // window_size is being written
  assign sample_ready = (!median_valid || median_ready) && !window_size_we;
  assign accept       = sample_valid && sample_ready;
  assign full         = (fill_count == win_len);

  always_comb begin
    ws_ext = XW'(window_size);
    if (ws_ext == '0) begin
      win_len_next = CW'(1);
    end else if (ws_ext > XW'(WINDOW_MAX)) begin
      win_len_next = CW'(WINDOW_MAX);
    end else begin
      win_len_next = CW'(ws_ext);
    end
  end

  always_comb begin
    fill_count_next = fill_count;
    oldest_ptr_next = oldest_ptr;
    ring_we         = 1'b0;
    ring_waddr      = oldest_ptr;
    result          = 1'b0;
    if (window_size_we) begin
      fill_count_next = '0;
      oldest_ptr_next = '0;
    end else if (accept) begin
      ring_we = 1'b1;
      if (!full) begin
        // still filling: append in arrival order
        ring_waddr      = fill_count[PW-1:0];
        fill_count_next = fill_count + CW'(1);
        result          = (fill_count + CW'(1) == win_len);
      end else begin
        ring_waddr = oldest_ptr;
        result     = 1'b1;
        if (CW'(oldest_ptr) + CW'(1) == win_len) begin
          oldest_ptr_next = '0;
        end else begin
          oldest_ptr_next = oldest_ptr + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= CW'(K_RST);
      fill_count <= '0;
      oldest_ptr <= '0;
    end else begin
      if (window_size_we) begin
        win_len <= win_len_next;
      end
      fill_count <= fill_count_next;
      oldest_ptr <= oldest_ptr_next;
    end
  end

  // Ring of arrivals; read address runs one transaction ahead so the
  // sample to evict is ready when the next one arrives.
  swm_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (sample),
    .raddr (oldest_ptr_next),
    .rdata (ring_rdata)
  );

  always_ff @(posedge clk) begin
    byp_hit  <= ring_we && (ring_waddr == oldest_ptr_next);
    byp_data <= sample;
  end

  assign old_key = byp_hit ? byp_data : $signed(ring_rdata);

  assign ctrl.step  = accept && !window_size_we;
  assign ctrl.evict = full;
  assign live_cnt   = full ? (win_len - CW'(1)) : fill_count;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] key_lo;
    logic signed [SAMPLE_WIDTH-1:0] key_hi;
    swm_flags_t                     flg_lo;
    swm_flags_t                     flg_hi;

    if (i == 0) begin : g_first
      assign key_lo = '0;
      assign flg_lo = '0;
    end else begin : g_lo
      assign key_lo = cell_key[i-1];
      assign flg_lo = cell_flg[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign key_hi = '0;
      assign flg_hi = '0;
    end else begin : g_hi
      assign key_hi = cell_key[i+1];
      assign flg_hi = cell_flg[i+1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .CW           (CW),
      .INDEX        (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .live_cnt (live_cnt),
      .new_key  (sample),
      .old_key  (old_key),
      .key_lo   (key_lo),
      .flg_lo   (flg_lo),
      .key_hi   (key_hi),
      .flg_hi   (flg_hi),
      .key      (cell_key[i]),
      .flg      (cell_flg[i]),
      .key_next (cell_next[i])
    );
  end

  // lower median: rank ceil(k/2), zero-based (k-1)/2
  assign mid_rank = (win_len - CW'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (result) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result) begin
      median <= cell_next[mid_rank[PW-1:0]];
    end
  end

endmodule

[sim/sliding_window_median_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit_tb
// Self-checking regression for the running lower-median filter.
// A short table of directed transactions covers reset state, extreme samples,
// duplicate eviction and window sizes 0, 1, 2, 3 and 4. Random phases then
// sweep window sizes from 1 up to the saturating values under four traffic
// patterns. Every median is checked against a typed value or the window model.
// ----------------------------------------------------------------------------
module sliding_window_median_unit_tb;
  import swm_pkg::*;

  localparam int WIN_MAX     = WINDOW_MAX_DEF;
  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int DRAIN_CYC   = 4;       // block answers in the cycle after accept
  localparam int MAX_CYCLES  = 200000;
  localparam int N_PHASES    = 10;
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef enum logic [1:0] {
    TRAFFIC_FREE,        // no idling on either side
    TRAFFIC_SRC_IDLE,    // sender idle odds 73 percent
    TRAFFIC_SINK_STALL,  // receiver stall odds 73 percent
    TRAFFIC_BOTH         // both at 33 percent
  } traffic_t;

  // One row of the directed table. A typed median is used where the answer
  // is obvious; otherwise the window model decides.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_WIDTH-1:0]  size;
    logic signed [SW-1:0]  value;
    bit                    typed;
    logic signed [SW-1:0]  median;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  window_size_we = 1'b0;
  logic [CFG_WIDTH-1:0]  window_size = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic signed [SW-1:0]  sample = '0;
  logic                  median_valid;
  logic                  median_ready = 1'b0;
  logic signed [SW-1:0]  median;

  sliding_window_median_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .window_size_we (window_size_we),
    .window_size    (window_size),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .sample         (sample),
    .median_valid   (median_valid),
    .median_ready   (median_ready),
    .median         (median)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window model: same state as the block, arrival ring plus sorted copy.
  // --------------------------------------------------------------------------
  logic [CFG_WIDTH-1:0]  win_reg = CFG_WIDTH'(WINDOW_RESET);
  logic signed [SW-1:0]  win_sorted [WIN_MAX];
  logic signed [SW-1:0]  win_arrival[WIN_MAX];
  int                    win_fill = 0;
  int                    win_oldest = 0;

  logic signed [SW-1:0]  medians_due[$];   // medians owed by the block, in order
  traffic_t              traffic = TRAFFIC_FREE;
  int                    err_count = 0;
  int                    samples_sent = 0;
  int                    medians_seen = 0;
  int                    cfg_writes = 0;
  int                    cycle_count = 0;

  // Push one sample into the model window. Returns 1 when a median comes out.
  function automatic bit median_update(input logic signed [SW-1:0] s,
                                       output logic signed [SW-1:0] med);
    int k;
    int i;
    int n;
    logic signed [SW-1:0] gone;
    // size 0 acts as 1, anything above the store saturates
    k = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg));
    if (win_fill > k) win_fill = k;
    if (win_oldest >= k) win_oldest = 0;
    med = '0;
    if (win_fill < k) begin
      n = win_fill;
      win_arrival[win_fill] = s;
      win_fill++;
    end else begin
      // evict exactly one copy of the oldest sample
      gone = win_arrival[win_oldest];
      i = 0;
      while (i < k && win_sorted[i] != gone) i++;
      while (i + 1 < k) begin
        win_sorted[i] = win_sorted[i + 1];
        i++;
      end
      n = k - 1;
      win_arrival[win_oldest] = s;
      win_oldest = (win_oldest + 1 >= k) ? 0 : win_oldest + 1;
    end
    i = n;
    while (i > 0 && win_sorted[i - 1] > s) begin
      win_sorted[i] = win_sorted[i - 1];
      i--;
    end
    win_sorted[i] = s;
    if (win_fill < k) return 1'b0;
    med = win_sorted[(k - 1) / 2];   // lower median, rank ceil(k/2)
    return 1'b1;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 6)) - 3;  // lots of duplicates
      7:          return SMIN + $urandom_range(0, 2);
      8:          return SMAX - $urandom_range(0, 2);
      default:    return $urandom_range(0, 255);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. All tasks are entered and left on a rising edge.
  // --------------------------------------------------------------------------

  // Writes window_size once the block is idle: nothing owed, plus a DRAIN_CYC
  // wait for samples that only filled the window and gave no median.
  task automatic set_window(input logic [CFG_WIDTH-1:0] v);
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    window_size_we <= 1'b1;
    window_size    <= v;
    @(posedge clk);
    window_size_we <= 1'b0;
    win_reg    = v;
    win_fill   = 0;
    win_oldest = 0;
    cfg_writes++;
  endtask

  // One sample transaction. hold makes the sender wait for every owed median.
  task automatic push_sample(input logic signed [SW-1:0] v, input bit typed,
                             input logic signed [SW-1:0] typed_med, input bit hold);
    int n_idle;
    int pct;
    logic signed [SW-1:0] med;
    n_idle = 0;
    pct = (traffic == TRAFFIC_SRC_IDLE) ? 73 : (traffic == TRAFFIC_BOTH) ? 33 : 0;
    while (n_idle < 40 && $urandom_range(0, 99) < pct) n_idle++;
    if (hold || n_idle > 0) begin
      sample_valid <= 1'b0;
      repeat (n_idle) @(posedge clk);
      if (hold) begin
        do @(posedge clk); while (medians_due.size() != 0);
      end
    end
    sample_valid <= 1'b1;
    sample       <= v;
    do @(posedge clk); while (!sample_ready);
    // accepted at this edge
    samples_sent++;
    if (median_update(v, med)) begin
      if (typed) med = typed_med;
      medians_due.push_back(med);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: random stalls and the median check.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    int pct;
    logic signed [SW-1:0] want;
    pct = (traffic == TRAFFIC_SINK_STALL) ? 73 : (traffic == TRAFFIC_BOTH) ? 33 : 0;
    if (!rst && median_valid && median_ready) begin
      medians_seen++;
      if (medians_due.size() == 0) begin
        $error("median: unexpected transaction, actual %0d", median);
        err_count++;
      end else begin
        want = medians_due.pop_front();
        if (median !== want) begin
          $error("median mismatch: expected %0d, actual %0d", want, median);
          err_count++;
        end
      end
    end
    median_ready <= ($urandom_range(0, 99) >= pct);
  end

  // Watchdog: a hang or a lost median ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("sliding_window_median_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  stim_row_t dir_rows[$];
  int phase_size[N_PHASES] = '{64, 127, 7, 1, 100, 2, 5, 65, 12, 3};
  int phase_len [N_PHASES] = '{110, 100, 60, 40, 90, 50, 60, 90, 60, 40};

  initial begin
    // reset window is 3: two fills then a median; duplicates then evicted
    dir_rows.push_back('{ROW_SAMPLE, '0, 5, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, -7, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 2, 1'b1, 2});
    dir_rows.push_back('{ROW_SAMPLE, '0, 2, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 2, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, -7, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 40, 1'b0, '0});
    // size 0 behaves as 1: median is the sample itself
    dir_rows.push_back('{ROW_CFG, 7'd0, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b1, SMIN});
    dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b1, SMAX});
    dir_rows.push_back('{ROW_SAMPLE, '0, 0, 1'b1, 0});
    dir_rows.push_back('{ROW_SAMPLE, '0, -1, 1'b1, -1});
    // even window: the smaller middle value
    dir_rows.push_back('{ROW_CFG, 7'd2, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, SMIN, 1'b1, SMIN});
    dir_rows.push_back('{ROW_SAMPLE, '0, SMAX, 1'b1, SMIN});
    dir_rows.push_back('{ROW_SAMPLE, '0, 10, 1'b0, '0});
    dir_rows.push_back('{ROW_CFG, 7'd1, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 123, 1'b1, 123});
    dir_rows.push_back('{ROW_CFG, 7'd4, '0, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 1, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 1, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 1, 1'b0, '0});
    dir_rows.push_back('{ROW_SAMPLE, '0, 1, 1'b1, 1});
    dir_rows.push_back('{ROW_SAMPLE, '0, -3, 1'b0, '0});

    phase_size[8] = $urandom_range(4, 31);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        sample_valid <= 1'b0;
        set_window(dir_rows[r].size);
      end else begin
        push_sample(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].median, 1'b0);
      end
    end
    sample_valid <= 1'b0;

    // random phases: each one rewrites the window and cycles the traffic mix;
    // sizes 65, 100 and 127 saturate to the full store
    for (int p = 0; p < N_PHASES; p++) begin
      set_window(CFG_WIDTH'(phase_size[p]));
      traffic = traffic_t'(p % 4);
      for (int j = 0; j < phase_len[p]; j++) begin
        push_sample(pick_sample(), 1'b0, '0, (p == 2 && j == phase_len[p] / 2));
      end
      sample_valid <= 1'b0;
    end

    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC * 2) @(posedge clk);

    $display("covered %0d samples and %0d medians over %0d window_size writes,",
             samples_sent, medians_seen, cfg_writes);
    $display("window sizes 0 through 127 under free, idle, stall and mixed traffic");
    if (err_count == 0) begin
      $display("sliding_window_median_unit regression: pass");
    end else begin
      $display("sliding_window_median_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
sv/swm_pkg.sv
sv/swm_ram.sv
sv/swm_cell.sv
sv/sliding_window_median_unit.sv
sim/sliding_window_median_unit_tb.sv
